// ===== hw/rtl/luiwd_pkg.sv =====
package luiwd_pkg;

  // Default table geometry.
  localparam int NUM_WORKERS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths of the request and response channels and of the configuration write data.
  localparam int ACT_W    = 2;
  localparam int WID_W    = 3;
  localparam int WORD_W   = 32;
  localparam int CODE_W   = 2;
  localparam int CFG_W    = 4;

  // Worker count after reset.
  localparam int WORKER_COUNT_RST = 8;

  // Request kinds.
  typedef enum logic [ACT_W-1:0] {
    ACT_ASSIGN = 2'd0,
    ACT_START  = 2'd1,
    ACT_DONE   = 2'd2
  } action_t;

  // Response codes.
  typedef enum logic [CODE_W-1:0] {
    RC_OK       = 2'd0,
    RC_ALL_BUSY = 2'd1,
    RC_MISMATCH = 2'd2
  } rc_t;

  // Worker status kept in the table.
  typedef enum logic [1:0] {
    WS_IDLE     = 2'd0,
    WS_ASSIGNED = 2'd1,
    WS_BUSY     = 2'd2
  } wstate_t;

endpackage

// ===== hw/rtl/luiwd_ifs.sv =====
// Request channel: one event for the dispatcher.
interface luiwd_req_if;
  logic                          valid;
  logic                          ready;
  logic [luiwd_pkg::ACT_W-1:0]   action;
  logic [luiwd_pkg::WID_W-1:0]   worker_id;
  logic [luiwd_pkg::WORD_W-1:0]  task_handle;
  logic [luiwd_pkg::WORD_W-1:0]  task_argument;

  modport source (output valid, output action, output worker_id,
                  output task_handle, output task_argument, input ready);
  modport sink   (input valid, input action, input worker_id,
                  input task_handle, input task_argument, output ready);
endinterface

// Response channel: one result for each request.
interface luiwd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [luiwd_pkg::CODE_W-1:0]  result_code;
  logic [luiwd_pkg::WID_W-1:0]   chosen_worker;
  logic [luiwd_pkg::WORD_W-1:0]  dispatched_handle;
  logic [luiwd_pkg::WORD_W-1:0]  dispatched_argument;

  modport source (output valid, output result_code, output chosen_worker,
                  output dispatched_handle, output dispatched_argument, input ready);
  modport sink   (input valid, input result_code, input chosen_worker,
                  input dispatched_handle, input dispatched_argument, output ready);
endinterface

// ===== hw/rtl/luiwd_table.sv =====
module luiwd_table #(
  parameter int NUM_WORKERS = luiwd_pkg::NUM_WORKERS_DEF,
  parameter int COUNT_WIDTH = luiwd_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W-1:0]        raddr,
  output luiwd_pkg::wstate_t      rd_state,
  output logic [COUNT_WIDTH-1:0]  rd_count,
  input  logic                    we,
  input  logic [IDX_W-1:0]        waddr,
  input  luiwd_pkg::wstate_t      wr_state,
  input  logic [COUNT_WIDTH-1:0]  wr_count
);
  import luiwd_pkg::*;

  localparam int ENTRY_W = COUNT_WIDTH + 2;

  logic [ENTRY_W-1:0]     mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] vld;
  logic [ENTRY_W-1:0]     rd_q;
  logic                   rd_v;

  // Entry valid bits: an entry never written reads as idle with a zero count.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Table storage, one write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wr_state, wr_count};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
    rd_v <= vld[raddr];
  end

  assign rd_state = rd_v ? wstate_t'(rd_q[ENTRY_W-1 -: 2]) : WS_IDLE;
  assign rd_count = rd_v ? rd_q[COUNT_WIDTH-1:0] : '0;

endmodule

// ===== hw/rtl/least_used_idle_worker_dispatcher_core.sv =====
// Least-used idle worker dispatcher.
// Requests arrive on the req channel (valid/ready) and carry an action, a
// worker id and a task handle and argument. Each request yields exactly one
// response on the rsp channel: a result code, the chosen or echoed worker and
// the dispatched handle and argument (zero unless an assign succeeded).
// The worker table sits in a synchronous memory with one read and one write
// port. An assign walks the first n entries one per cycle, n being
// worker_count capped at the table size; start and done read one entry. One
// request is in flight at a time; the next one is taken as soon as the
// previous result is in the output register, even while that register still
// waits on the sink.
// If the sink stalls, the finished result waits in the final state and the
// block takes no new request. Reset empties the table (all workers idle with
// zero counts, by per-entry valid bits), drops the response valid and
// sets worker_count to 8. cfg_we writes worker_count; values above the table
// size act as the table size.
module least_used_idle_worker_dispatcher_core #(
  parameter int NUM_WORKERS = luiwd_pkg::NUM_WORKERS_DEF,
  parameter int COUNT_WIDTH = luiwd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [luiwd_pkg::CFG_W-1:0] cfg_wdata,
  luiwd_req_if.sink                   req,
  luiwd_rsp_if.source                 rsp
);
  import luiwd_pkg::*;

  localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int NW_W  = $clog2(NUM_WORKERS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_CHK  = 5'b01000,
    S_FIN  = 5'b10000
  } fsm_t;

  fsm_t                   state;
  logic [CFG_W-1:0]       worker_count;
  logic [NW_W-1:0]        n_eff;
  logic                   wid_ok;
  logic                   out_free;
  logic                   is_asg;

  logic [ACT_W-1:0]       act;
  logic [WID_W-1:0]       wid;
  logic [WORD_W-1:0]      hnd;
  logic [WORD_W-1:0]      arg;
  logic [IDX_W-1:0]       ptr;
  logic                   cmp_on;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [COUNT_WIDTH-1:0] best_cnt;
  rc_t                    res_code;
  logic                   wr_pend;
  wstate_t                wr_state;
  logic [COUNT_WIDTH-1:0] wr_cnt;

  logic [IDX_W-1:0]       raddr;
  wstate_t                rd_state;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_waddr;
  wstate_t                tbl_wstate;
  logic [COUNT_WIDTH-1:0] tbl_wcount;

  // Effective worker count, saturated to the table size.
  always_comb begin
    if (32'(worker_count) > NUM_WORKERS) begin
      n_eff = NW_W'(NUM_WORKERS);
    end else begin
      n_eff = NW_W'(worker_count);
    end
  end

  assign wid_ok   = 32'(req.worker_id) < 32'(n_eff);
  assign out_free = !rsp.valid || rsp.ready;
  assign is_asg   = (act == ACT_ASSIGN);
  assign req.ready = (state == S_IDLE);

  // Read address: the scan pointer while scanning, else the requested worker.
  assign raddr = (state == S_SCAN) ? ptr : IDX_W'(req.worker_id);

  // Write-back happens once, when the response is loaded.
  assign tbl_we     = (state == S_FIN) && out_free && (is_asg ? found : wr_pend);
  assign tbl_waddr  = is_asg ? best_idx : IDX_W'(wid);
  assign tbl_wstate = is_asg ? WS_ASSIGNED : wr_state;
  assign tbl_wcount = is_asg ? best_cnt : wr_cnt;

  luiwd_table #(
    .NUM_WORKERS (NUM_WORKERS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .raddr    (raddr),
    .rd_state (rd_state),
    .rd_count (rd_count),
    .we       (tbl_we),
    .waddr    (tbl_waddr),
    .wr_state (tbl_wstate),
    .wr_count (tbl_wcount)
  );

  // Control: configuration, state sequencing and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      worker_count <= CFG_W'(WORKER_COUNT_RST);
      rsp.valid    <= 1'b0;
      cmp_on       <= 1'b0;
    end else begin
      if (cfg_we) begin
        worker_count <= cfg_wdata;
      end
      // A new result takes the register; otherwise a taken result leaves it.
      if ((state == S_FIN) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      cmp_on <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            case (req.action)
              ACT_ASSIGN: state <= (n_eff == '0) ? S_FIN : S_SCAN;
              ACT_START, ACT_DONE: state <= wid_ok ? S_CHK : S_FIN;
              default: state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if ((32'(ptr) + 32'd1) == 32'(n_eff)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: state <= S_FIN;
        S_CHK:  state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: request capture, scan compare, status check and response load.
  always_ff @(posedge clk) begin
    cmp_idx <= ptr;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act      <= req.action;
          wid      <= req.worker_id;
          hnd      <= req.task_handle;
          arg      <= req.task_argument;
          ptr      <= '0;
          found    <= 1'b0;
          wr_pend  <= 1'b0;
          res_code <= RC_MISMATCH;
        end
      end
      S_SCAN, S_TAIL: begin
        if (state == S_SCAN) begin
          ptr <= ptr + 1'b1;
        end
        // Keep the idle worker with the lowest count; ties keep the earlier one.
        if (cmp_on && rd_state == WS_IDLE && (!found || rd_count < best_cnt)) begin
          found    <= 1'b1;
          best_idx <= cmp_idx;
          best_cnt <= rd_count;
        end
      end
      S_CHK: begin
        case (act)
          ACT_START: begin
            if (rd_state == WS_ASSIGNED) begin
              wr_pend  <= 1'b1;
              wr_state <= WS_BUSY;
              wr_cnt   <= COUNT_WIDTH'(rd_count + 1'b1);
              res_code <= RC_OK;
            end
          end
          ACT_DONE: begin
            if (rd_state == WS_BUSY) begin
              wr_pend  <= 1'b1;
              wr_state <= WS_IDLE;
              wr_cnt   <= rd_count;
              res_code <= RC_OK;
            end
          end
          default: res_code <= RC_MISMATCH;
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          if (is_asg && found) begin
            rsp.result_code         <= RC_OK;
            rsp.chosen_worker       <= WID_W'(best_idx);
            rsp.dispatched_handle   <= hnd;
            rsp.dispatched_argument <= arg;
          end else if (is_asg) begin
            rsp.result_code         <= RC_ALL_BUSY;
            rsp.chosen_worker       <= '0;
            rsp.dispatched_handle   <= '0;
            rsp.dispatched_argument <= '0;
          end else begin
            rsp.result_code         <= res_code;
            rsp.chosen_worker       <= wid;
            rsp.dispatched_handle   <= '0;
            rsp.dispatched_argument <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/least_used_idle_worker_dispatcher_core_tb.sv =====
`timescale 1ns / 100ps

module least_used_idle_worker_dispatcher_core_tb;
  import luiwd_pkg::*;

  localparam int unsigned NW = NUM_WORKERS_DEF;
  localparam int unsigned CW = COUNT_WIDTH_DEF;
  // Cycles to let the block settle before a register write.
  localparam int unsigned SETTLE_CYCLES = NW + 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  // The long receiver hold-off starts after this many responses.
  localparam int unsigned HOLD_AFTER = 700;
  localparam int unsigned HOLD_CYCLES = 300;
  // The action value that no request kind uses.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Random phases: worker count, request count and idling percentages.
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORKERS [PHASES] = '{1, 8, 0, 4, 15, 2, 9, 8};
  localparam int unsigned PHASE_ITEMS [PHASES] = '{190, 220, 60, 200, 230, 180, 190, 180};
  localparam int unsigned PHASE_SRC_GAP [PHASES] = '{0, 30, 20, 0, 40, 10, 25, 0};
  localparam int unsigned PHASE_SNK_STALL [PHASES] = '{30, 0, 20, 40, 0, 25, 10, 35};

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [WID_W-1:0]  worker_id;
    logic [WORD_W-1:0] task_handle;
    logic [WORD_W-1:0] task_argument;
  } dispatch_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [WID_W-1:0]  chosen_worker;
    logic [WORD_W-1:0] dispatched_handle;
    logic [WORD_W-1:0] dispatched_argument;
  } dispatch_rsp_t;

  // Tracks the worker table and the outcomes still owed by the block.
  class dispatch_scoreboard;
    wstate_t           worker_st [NW];
    logic [CW-1:0]     use_cnt [NW];
    int unsigned       worker_count;
    dispatch_rsp_t     expected_outcomes [$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      for (int i = 0; i < NW; i++) begin
        worker_st[i] = WS_IDLE;
        use_cnt[i] = '0;
      end
      worker_count = WORKER_COUNT_RST;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned active_workers();
      return (worker_count > NW) ? NW : worker_count;
    endfunction

    function void set_worker_count(int unsigned value);
      worker_count = value;
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction

    // Apply one accepted request to the table and queue its outcome.
    function void note_request(dispatch_req_t item);
      dispatch_rsp_t outcome;
      int unsigned   n;
      int unsigned   best;
      logic [CW-1:0] best_cnt;
      bit            found;
      n = active_workers();
      outcome.result_code = RC_MISMATCH;
      outcome.chosen_worker = item.worker_id;
      outcome.dispatched_handle = '0;
      outcome.dispatched_argument = '0;
      found = 1'b0;
      best = 0;
      best_cnt = '0;
      case (item.action)
        ACT_ASSIGN: begin
          // Least-used idle worker wins; the lowest index breaks a tie.
          for (int i = 0; i < n; i++) begin
            if (worker_st[i] == WS_IDLE && (!found || use_cnt[i] < best_cnt)) begin
              found = 1'b1;
              best = i;
              best_cnt = use_cnt[i];
            end
          end
          if (found) begin
            worker_st[best] = WS_ASSIGNED;
            outcome.result_code = RC_OK;
            outcome.chosen_worker = best[WID_W-1:0];
            outcome.dispatched_handle = item.task_handle;
            outcome.dispatched_argument = item.task_argument;
          end else begin
            outcome.result_code = RC_ALL_BUSY;
            outcome.chosen_worker = '0;
          end
        end
        ACT_START: begin
          if (item.worker_id < n && worker_st[item.worker_id] == WS_ASSIGNED) begin
            worker_st[item.worker_id] = WS_BUSY;
            use_cnt[item.worker_id] = use_cnt[item.worker_id] + 1'b1;
            outcome.result_code = RC_OK;
          end
        end
        ACT_DONE: begin
          if (item.worker_id < n && worker_st[item.worker_id] == WS_BUSY) begin
            worker_st[item.worker_id] = WS_IDLE;
            outcome.result_code = RC_OK;
          end
        end
        default: begin
          // The unused action value is rejected and changes nothing.
        end
      endcase
      expected_outcomes.push_back(outcome);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    // Compare one response with the oldest outstanding outcome.
    function void check_result(dispatch_rsp_t seen);
      dispatch_rsp_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, expected none, got %h",
                 $time, seen);
        return;
      end
      want = expected_outcomes.pop_front();
      checked++;
      compare_field("result_code", want.result_code, seen.result_code);
      compare_field("chosen_worker", want.chosen_worker, seen.chosen_worker);
      compare_field("dispatched_handle", want.dispatched_handle, seen.dispatched_handle);
      compare_field("dispatched_argument", want.dispatched_argument, seen.dispatched_argument);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned cycle_count = 0;
  int unsigned src_gap_pct;
  int unsigned snk_stall_pct;
  dispatch_scoreboard sb;

  luiwd_req_if req_ch ();
  luiwd_rsp_if rsp_ch ();

  least_used_idle_worker_dispatcher_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Known values on every input from time zero.
  initial begin
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.worker_id = '0;
    req_ch.task_handle = '0;
    req_ch.task_argument = '0;
    rsp_ch.ready = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_span();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Response monitor.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result({rsp_ch.result_code, rsp_ch.chosen_worker,
                       rsp_ch.dispatched_handle, rsp_ch.dispatched_argument});
    end
  end

  // Response ready: random stalls plus one long hold-off that backs up the block.
  initial begin
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        stall_left = idle_span() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays high if
  // another request follows with no gap.
  task automatic offer_request(input dispatch_req_t item);
    req_ch.valid <= 1'b1;
    req_ch.action <= item.action;
    req_ch.worker_id <= item.worker_id;
    req_ch.task_handle <= item.task_handle;
    req_ch.task_argument <= item.task_argument;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(item);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat (idle_span()) @(posedge clk);
    end
  endtask

  task automatic directed_request(input logic [ACT_W-1:0] act, input int unsigned wid,
                                  input logic [WORD_W-1:0] handle,
                                  input logic [WORD_W-1:0] argument);
    offer_request({act, wid[WID_W-1:0], handle, argument});
  endtask

  // Mostly legal lifecycles (assign, start the assigned, finish the busy)
  // over the active workers, with random noise mixed in.
  task automatic pick_request(output dispatch_req_t item);
    int unsigned roll;
    int unsigned n;
    int unsigned assigned_ids [$];
    int unsigned busy_ids [$];
    n = sb.active_workers();
    for (int i = 0; i < n; i++) begin
      if (sb.worker_st[i] == WS_ASSIGNED) assigned_ids.push_back(i);
      if (sb.worker_st[i] == WS_BUSY) busy_ids.push_back(i);
    end
    item.worker_id = WID_W'($urandom_range(0, NW - 1));
    item.task_handle = rand_word();
    item.task_argument = rand_word();
    roll = $urandom_range(0, 99);
    if (roll >= 80) begin
      item.action = ACT_W'($urandom_range(0, 3));
    end else if (roll < 30 && assigned_ids.size() > 0) begin
      item.action = ACT_START;
      item.worker_id = WID_W'(assigned_ids[$urandom_range(0, assigned_ids.size() - 1)]);
    end else if (roll < 55 && busy_ids.size() > 0) begin
      item.action = ACT_DONE;
      item.worker_id = WID_W'(busy_ids[$urandom_range(0, busy_ids.size() - 1)]);
    end else begin
      item.action = ACT_ASSIGN;
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Stop offering, let every response come back, then write worker_count.
  task automatic settle_and_configure(input int unsigned value);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_worker_count(value);
  endtask

  initial begin
    dispatch_req_t item;
    sb = new();
    src_gap_pct = 20;
    snk_stall_pct = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill and drain the table at the reset worker count.
    directed_request(ACT_ASSIGN, 7, '0, '0);
    directed_request(ACT_ASSIGN, 0, '1, '1);
    directed_request(ACT_START, 0, 32'h1234_5678, 32'h9abc_def0);
    directed_request(ACT_START, 0, '0, '0);
    directed_request(ACT_DONE, 1, '0, '0);
    directed_request(ACT_START, 1, '0, '0);
    directed_request(ACT_DONE, 0, '0, '0);
    // Worker 0 is now used once, so the next assign goes to worker 2.
    directed_request(ACT_ASSIGN, 3, 32'hdead_beef, 32'h0000_0001);
    directed_request(ACT_UNUSED, 7, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    directed_request(ACT_DONE, 5, '0, '0);
    directed_request(ACT_START, 7, '0, '0);
    for (int i = 0; i < 6; i++) begin
      directed_request(ACT_ASSIGN, i, rand_word(), rand_word());
    end
    // Every worker is taken now.
    directed_request(ACT_ASSIGN, 0, 32'h8000_0000, 32'h7fff_ffff);
    directed_request(ACT_DONE, 1, '0, '0);
    directed_request(ACT_ASSIGN, 6, 32'h0000_ffff, 32'hffff_0000);

    // No workers in use: assign finds nobody and every id is out of range.
    settle_and_configure(0);
    directed_request(ACT_ASSIGN, 0, '1, '1);
    directed_request(ACT_START, 0, '0, '0);
    // Worker 5 is assigned but lies beyond the active range.
    settle_and_configure(3);
    directed_request(ACT_START, 5, '0, '0);
    directed_request(ACT_START, 2, '0, '0);
    // A count above the table size acts as the table size.
    settle_and_configure(15);
    directed_request(ACT_START, 5, '0, '0);

    // Random phases over several worker counts and idling mixes.
    for (int p = 0; p < PHASES; p++) begin
      settle_and_configure(PHASE_WORKERS[p]);
      src_gap_pct = PHASE_SRC_GAP[p];
      snk_stall_pct = PHASE_SNK_STALL[p];
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        pick_request(item);
        offer_request(item);
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
